// ----- hw/rtl/lmt_pkg.sv -----
`timescale 1ns / 1ps

package lmt_pkg;

	// Display modes, encoded as the status register reports them.
	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_DRAW   = 2'd3
	} mode_t;

	// Tick operation codes. Code 3 is reserved and leaves the state alone.
	localparam logic [1:0] OP_ADVANCE = 2'd0;
	localparam logic [1:0] OP_LCD_OFF = 2'd1;
	localparam logic [1:0] OP_LCD_ON  = 2'd2;

	// Configuration register indexes.
	localparam logic [0:0] REG_LINE_COMPARE = 1'b0;
	localparam logic [0:0] REG_IRQ_ENABLES  = 1'b1;

	// Bits of the status interrupt enable register.
	localparam int IRQ_EN_HBLANK  = 0;
	localparam int IRQ_EN_VBLANK  = 1;
	localparam int IRQ_EN_OAM     = 2;
	localparam int IRQ_EN_COMPARE = 3;

	localparam logic [9:0] DOT_COUNT_MAX = 10'd1023;
	localparam logic [9:0] DOT_COUNT_ON  = 10'd4;

	typedef struct packed {
		logic [1:0] operation;
		logic [6:0] dots;
	} tick_t;

	typedef struct packed {
		logic [7:0] line;
		logic [1:0] status_mode;
		logic       compare_match;
		logic       vblank_irq;
		logic       status_irq;
		logic       hblank_dma;
		logic       lcd_active;
	} stat_t;

	typedef struct packed {
		logic [7:0] line_compare;
		logic [3:0] irq_enables;
	} cfg_t;

	typedef struct packed {
		mode_t      mode;
		logic [9:0] dots;
		logic [7:0] line;
		mode_t      status_mode;
		logic       compare_flag;
		logic       lcd_on;
	} timing_state_t;

endpackage

// ----- hw/rtl/lmt_step.sv -----
`timescale 1ns / 1ps

// Next-state and result logic for one tick: at most one mode transition.
module lmt_step #(
	parameter int OAM_DOTS      = 80,
	parameter int DRAW_DOTS     = 172,
	parameter int HBLANK_DOTS   = 204,
	parameter int VISIBLE_LINES = 144,
	parameter int TOTAL_LINES   = 154
) (
	input  lmt_pkg::timing_state_t cur,
	input  lmt_pkg::tick_t         tick,
	input  lmt_pkg::cfg_t          cfg,
	output lmt_pkg::timing_state_t nxt,
	output lmt_pkg::stat_t         stat
);

	localparam logic [10:0] OAM_W    = 11'(OAM_DOTS);
	localparam logic [10:0] DRAW_W   = 11'(DRAW_DOTS);
	localparam logic [10:0] HBLANK_W = 11'(HBLANK_DOTS);
	localparam logic [10:0] LINE_W   = 11'(OAM_DOTS + DRAW_DOTS + HBLANK_DOTS);
	localparam logic [7:0]  VIS_W    = 8'(VISIBLE_LINES);
	localparam logic [7:0]  TOT_W    = 8'(TOTAL_LINES);

	logic [10:0] sum;
	logic [10:0] cnt;
	logic [7:0]  line_inc;
	logic        inc_match;
	logic        vblank_p;
	logic        status_p;
	logic        dma_p;

	always_comb begin
		nxt      = cur;
		vblank_p = 1'b0;
		status_p = 1'b0;
		dma_p    = 1'b0;
		sum      = {1'b0, cur.dots} + {4'd0, tick.dots};
		cnt      = (sum > {1'b0, lmt_pkg::DOT_COUNT_MAX}) ? {1'b0, lmt_pkg::DOT_COUNT_MAX} : sum;
		line_inc = cur.line + 8'd1;
		inc_match = (line_inc == cfg.line_compare);

		unique case (tick.operation)
			lmt_pkg::OP_ADVANCE: begin
				if (cur.lcd_on) begin
					nxt.dots = cnt[9:0];
					unique case (cur.mode)
						lmt_pkg::MODE_OAM: begin
							if (cnt >= OAM_W) begin
								nxt.dots        = 10'(cnt - OAM_W);
								nxt.mode        = lmt_pkg::MODE_DRAW;
								nxt.status_mode = lmt_pkg::MODE_DRAW;
							end
						end
						lmt_pkg::MODE_DRAW: begin
							if (cnt >= DRAW_W) begin
								nxt.dots        = 10'(cnt - DRAW_W);
								nxt.mode        = lmt_pkg::MODE_HBLANK;
								nxt.status_mode = lmt_pkg::MODE_HBLANK;
								status_p        = cfg.irq_enables[lmt_pkg::IRQ_EN_HBLANK];
								dma_p           = (cur.line < VIS_W);
							end
						end
						lmt_pkg::MODE_HBLANK: begin
							if (cnt >= HBLANK_W) begin
								nxt.dots         = 10'(cnt - HBLANK_W);
								nxt.line         = line_inc;
								nxt.compare_flag = inc_match;
								status_p = inc_match & cfg.irq_enables[lmt_pkg::IRQ_EN_COMPARE];
								if (line_inc >= VIS_W) begin
									nxt.mode        = lmt_pkg::MODE_VBLANK;
									nxt.status_mode = lmt_pkg::MODE_VBLANK;
									vblank_p        = 1'b1;
									status_p = status_p | cfg.irq_enables[lmt_pkg::IRQ_EN_VBLANK];
								end else begin
									nxt.mode        = lmt_pkg::MODE_OAM;
									nxt.status_mode = lmt_pkg::MODE_OAM;
									status_p = status_p | cfg.irq_enables[lmt_pkg::IRQ_EN_OAM];
								end
							end
						end
						lmt_pkg::MODE_VBLANK: begin
							if (cnt >= LINE_W) begin
								nxt.dots         = 10'(cnt - LINE_W);
								nxt.line         = line_inc;
								nxt.compare_flag = inc_match;
								status_p = inc_match & cfg.irq_enables[lmt_pkg::IRQ_EN_COMPARE];
								// The compare is not repeated at the wrap to line 0.
								if (line_inc >= TOT_W) begin
									nxt.line        = 8'd0;
									nxt.mode        = lmt_pkg::MODE_OAM;
									nxt.status_mode = lmt_pkg::MODE_OAM;
									status_p = status_p | cfg.irq_enables[lmt_pkg::IRQ_EN_OAM];
								end
							end
						end
					endcase
				end
			end
			lmt_pkg::OP_LCD_OFF: begin
				if (cur.lcd_on) begin
					nxt.lcd_on      = 1'b0;
					nxt.line        = 8'd0;
					nxt.dots        = 10'd0;
					nxt.mode        = lmt_pkg::MODE_HBLANK;
					nxt.status_mode = lmt_pkg::MODE_HBLANK;
				end
			end
			lmt_pkg::OP_LCD_ON: begin
				if (!cur.lcd_on) begin
					nxt.lcd_on       = 1'b1;
					nxt.line         = 8'd0;
					nxt.dots         = lmt_pkg::DOT_COUNT_ON;
					nxt.mode         = lmt_pkg::MODE_OAM;
					nxt.status_mode  = lmt_pkg::MODE_HBLANK;
					nxt.compare_flag = (cfg.line_compare == 8'd0);
					status_p = (cfg.line_compare == 8'd0) &
						cfg.irq_enables[lmt_pkg::IRQ_EN_COMPARE];
				end
			end
			default: begin
				nxt = cur;
			end
		endcase

		stat.line          = nxt.line;
		stat.status_mode   = nxt.status_mode;
		stat.compare_match = nxt.compare_flag;
		stat.vblank_irq    = vblank_p;
		stat.status_irq    = status_p;
		stat.hblank_dma    = dma_p;
		stat.lcd_active    = nxt.lcd_on;
	end

endmodule

// ----- hw/rtl/lcd_mode_timing_stat_irq.sv -----
`timescale 1ns / 1ps

// LCD mode timing and status interrupt block.
//
// The tick channel (tick_valid, tick_stall, tick) carries one item per
// transfer: either a number of elapsed dots or a request to switch the display
// off or on. Every tick yields exactly one status item on the stat channel
// (stat_valid, stat_stall, stat): current line, status mode bits, the line
// compare flag and the vblank, status interrupt and hblank DMA strobes.
// The cfg channel writes line_compare (index 0) and the status interrupt
// enables (index 1); it is always ready and should be used while idle.
//
// A tick is captured in an input register, then the timing logic computes the
// new state combinationally and loads the status item into the output register.
// One tick is taken per cycle while the output is not stalled; the mode and
// dot counter registers carry over from item to item. When the receiver stalls,
// the output register holds its item and the input register still takes one
// more tick; beyond that tick_stall rises until the output drains.
// Reset puts the display on, in oam scan at line 0 with dot count 0, status
// mode 0, compare flag 0 and both configuration registers 0.
module lcd_mode_timing_stat_irq #(
	parameter int OAM_DOTS      = 80,
	parameter int DRAW_DOTS     = 172,
	parameter int HBLANK_DOTS   = 204,
	parameter int VISIBLE_LINES = 144,
	parameter int TOTAL_LINES   = 154
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tick_valid,
	output logic            tick_stall,
	input  lmt_pkg::tick_t  tick,
	output logic            stat_valid,
	input  logic            stat_stall,
	output lmt_pkg::stat_t  stat,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [0:0]      cfg_index,
	input  logic [7:0]      cfg_data
);

	lmt_pkg::tick_t         tick_s1;
	logic                   valid_s1;
	lmt_pkg::timing_state_t state_q;
	lmt_pkg::timing_state_t state_nxt;
	lmt_pkg::cfg_t          cfg_q;
	lmt_pkg::stat_t         stat_nxt;
	lmt_pkg::stat_t         stat_q;
	logic                   stat_valid_q;
	logic                   advance;
	logic                   tick_take;

	// The stage moves forward when the output register is free or draining.
	assign advance    = valid_s1 && (!stat_valid_q || !stat_stall);
	assign tick_stall = valid_s1 && !advance;
	assign tick_take  = tick_valid && !tick_stall;
	assign cfg_ready  = 1'b1;
	assign stat_valid = stat_valid_q;
	assign stat       = stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_take) begin
			tick_s1 <= tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_compare <= 8'd0;
			cfg_q.irq_enables  <= 4'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lmt_pkg::REG_LINE_COMPARE: cfg_q.line_compare <= cfg_data;
				lmt_pkg::REG_IRQ_ENABLES:  cfg_q.irq_enables  <= cfg_data[3:0];
			endcase
		end
	end

	lmt_step #(
		.OAM_DOTS      (OAM_DOTS),
		.DRAW_DOTS     (DRAW_DOTS),
		.HBLANK_DOTS   (HBLANK_DOTS),
		.VISIBLE_LINES (VISIBLE_LINES),
		.TOTAL_LINES   (TOTAL_LINES)
	) u_step (
		.cur  (state_q),
		.tick (tick_s1),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.stat (stat_nxt)
	);

	// Timing state follows each tick as it leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode         <= lmt_pkg::MODE_OAM;
			state_q.dots         <= 10'd0;
			state_q.line         <= 8'd0;
			state_q.status_mode  <= lmt_pkg::MODE_HBLANK;
			state_q.compare_flag <= 1'b0;
			state_q.lcd_on       <= 1'b1;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_valid_q <= 1'b0;
		end else if (advance) begin
			stat_valid_q <= 1'b1;
		end else if (!stat_stall) begin
			stat_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stat_q <= stat_nxt;
		end
	end

	// A held tick is not dropped while the output is blocked.
	a_tick_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("held tick lost");

	// While the display is off the timing counters stay parked.
	a_off_parked: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.lcd_on |-> (state_q.dots == 10'd0) && (state_q.line == 8'd0) &&
			(state_q.mode == lmt_pkg::MODE_HBLANK))
		else $error("counters move while display off");

	// An hblank DMA strobe only comes with hblank on a lit display.
	a_dma_mode: assert property (@(posedge clk) disable iff (!arst_n)
		stat_valid_q && stat_q.hblank_dma |->
			(stat_q.status_mode == lmt_pkg::MODE_HBLANK) && stat_q.lcd_active)
		else $error("hblank DMA outside hblank");

	// The vblank strobe marks entry into vblank.
	a_vblank_mode: assert property (@(posedge clk) disable iff (!arst_n)
		stat_valid_q && stat_q.vblank_irq |->
			(stat_q.status_mode == lmt_pkg::MODE_VBLANK) &&
			(stat_q.line == 8'(VISIBLE_LINES)))
		else $error("vblank strobe without vblank entry");

endmodule
